// ===== src/sacm_pkg.sv =====
// Shared package for the shared activation counter mitigation block.
// Field widths, opcode and config-index codes, controller states and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package sacm_pkg;

  // Default values for the top-level parameters
  localparam int RANK_COUNT_DEF     = 2;
  localparam int BANKS_PER_RANK_DEF = 32;
  localparam int ROW_BITS_DEF       = 16;
  localparam int COUNTER_BITS_DEF   = 16;

  // Item field widths
  localparam int OPCODE_W = 2;
  localparam int RANK_W   = 1;
  localparam int BANK_W   = 5;
  localparam int ROW_W    = 16;
  localparam int MASK_W   = 16;
  localparam int DRFM_W   = 4;
  localparam int INDEX_W  = 16;
  localparam int COUNT_W  = 16;

  // Stream payload widths (packed fields rounded up to whole bytes)
  localparam int IN_FIELDS_W  = RANK_W + BANK_W + ROW_W + MASK_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = DRFM_W + RANK_W + INDEX_W + COUNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  // Config register widths
  localparam int THR_W      = 16;
  localparam int SHARE_W    = 2;
  localparam int IVL_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Config register reset values
  localparam logic [THR_W-1:0]   THRESHOLD_RST = THR_W'(512);
  localparam logic [SHARE_W-1:0] SHARING_RST   = '0;
  localparam logic               GROUPING_RST  = 1'b1;
  localparam logic [IVL_W-1:0]   INTERVAL_RST  = IVL_W'(3125);

  // Opcodes (the remaining code behaves as an idle cycle)
  localparam logic [OPCODE_W-1:0] OP_IDLE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ACT  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_MASK = 2'd2;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHARING   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUPING  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL  = 2'd3;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MASKWR,
    ST_TICK,
    ST_LOOKUP,
    ST_UPDATE,
    ST_RESULT
  } state_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;     // latch the accepted item, zero the result
    logic mask_wr;  // write the bank mask table
    logic sweep;    // clear one counter word of the power-up pass
    logic tick;     // advance the cycle timer, clear cursor entry when due
    logic lookup;   // form table index, read counter word
    logic update;   // increment, compare, write back
    logic push;     // move result into the output register
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic sweep_done;  // power-up pass is at its last word
    logic in_is_mask;  // offered item is a mask write
    logic is_act;      // latched item is an activate to a valid rank
    logic out_free;    // output register can take a result now
  } sts_t;

endpackage

`default_nettype wire

// ===== src/sacm_ctrl.sv =====
// Controller FSM for the shared activation counter mitigation block.
// Sequences the power-up clear, item decode and counter read-modify-write.
// Depends on sacm_pkg.
`default_nettype none

module sacm_ctrl (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_tvalid,
  output logic            in_tready,
  input  sacm_pkg::sts_t  sts,
  output sacm_pkg::cmd_t  cmd
);
  import sacm_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.in_is_mask ? ST_MASKWR : ST_TICK;
        end
      end
      ST_MASKWR: begin
        cmd.mask_wr = 1'b1;
        state_nxt   = ST_RESULT;
      end
      ST_TICK: begin
        cmd.tick  = 1'b1;
        state_nxt = sts.is_act ? ST_LOOKUP : ST_RESULT;
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_RESULT;
      end
      ST_RESULT: begin
        // hold here while the previous result is still unread
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // An activate always goes through the counter lookup before its update
  a_update_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> $past(cmd.lookup))
    else $error("counter update without preceding lookup");

  // The tick always follows an accepted non-mask item
  a_tick_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick |-> $past(cmd.load) && !$past(sts.in_is_mask))
    else $error("tick without a timed item");

  // Items are never taken while the power-up clear is running
  a_no_load_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sweep |-> !cmd.load && !cmd.update)
    else $error("item activity during clear pass");

endmodule

`default_nettype wire

// ===== src/sacm_dpath.sv =====
// Datapath for the shared activation counter mitigation block: config
// registers, bank mask table, counter memory, reset timer, output register.
// Depends on sacm_pkg; driven by sacm_ctrl commands.
`default_nettype none

module sacm_dpath #(
  parameter int RANK_COUNT     = sacm_pkg::RANK_COUNT_DEF,
  parameter int BANKS_PER_RANK = sacm_pkg::BANKS_PER_RANK_DEF,
  parameter int ROW_BITS       = sacm_pkg::ROW_BITS_DEF,
  parameter int COUNTER_BITS   = sacm_pkg::COUNTER_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // input item
  input  wire  [sacm_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  wire  [sacm_pkg::OPCODE_W-1:0]       in_tuser,
  // config write
  input  wire                                 cfg_valid,
  input  wire  [sacm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [sacm_pkg::CFG_DATA_W-1:0]     cfg_data,
  // result
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [sacm_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tuser,
  // controller link
  input  sacm_pkg::cmd_t                      cmd,
  output sacm_pkg::sts_t                      sts
);
  import sacm_pkg::*;

  localparam int ENTRIES = 1 << ROW_BITS;
  localparam int WORD_W  = RANK_COUNT * COUNTER_BITS;
  localparam int MDEPTH  = RANK_COUNT * BANKS_PER_RANK;
  localparam int MADDR_W = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
  localparam int CMP_W   = (COUNTER_BITS > THR_W) ? COUNTER_BITS : THR_W;

  // ---------------------------------------------------------------- config
  logic [THR_W-1:0]   threshold_r;
  logic [SHARE_W-1:0] sharing_r;
  logic               grouping_r;
  logic [IVL_W-1:0]   interval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RST;
      sharing_r   <= SHARING_RST;
      grouping_r  <= GROUPING_RST;
      interval_r  <= INTERVAL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_THRESHOLD: threshold_r <= cfg_data[THR_W-1:0];
        CFG_SHARING:   sharing_r   <= cfg_data[SHARE_W-1:0];
        CFG_GROUPING:  grouping_r  <= cfg_data[0];
        CFG_INTERVAL:  interval_r  <= cfg_data[IVL_W-1:0];
        default: ;
      endcase
    end
  end

  // Entry mask: table entries = rows >> sharing
  logic [ROW_BITS-1:0] emask;
  assign emask = {ROW_BITS{1'b1}} >> sharing_r;

  // ------------------------------------------------------------ item fields
  logic [OPCODE_W-1:0] in_op;
  logic [RANK_W-1:0]   in_rank;
  logic [BANK_W-1:0]   in_bank;
  logic [ROW_W-1:0]    in_row;
  logic [MASK_W-1:0]   in_maskv;
  logic                in_rank_ok;
  logic                in_bank_ok;

  assign in_op    = in_tuser;
  assign in_rank  = in_tdata[0 +: RANK_W];
  assign in_bank  = in_tdata[RANK_W +: BANK_W];
  assign in_row   = in_tdata[RANK_W + BANK_W +: ROW_W];
  assign in_maskv = in_tdata[RANK_W + BANK_W + ROW_W +: MASK_W];
  assign in_rank_ok = int'(in_rank) < RANK_COUNT;
  assign in_bank_ok = int'(in_bank) < BANKS_PER_RANK;

  // Latched item
  logic [RANK_W-1:0]  rank_r;
  logic [ROW_W-1:0]   row_r;
  logic [MASK_W-1:0]  maskv_r;
  logic [MADDR_W-1:0] maddr_r;
  logic               mask_ok_r;
  logic               act_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rank_r    <= in_rank;
      row_r     <= in_row;
      maskv_r   <= in_maskv;
      maddr_r   <= MADDR_W'(int'(in_rank) * BANKS_PER_RANK + int'(in_bank));
      mask_ok_r <= in_rank_ok && in_bank_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else if (cmd.load) begin
      act_r <= (in_op == OP_ACT) && in_rank_ok;
    end
  end

  // -------------------------------------------------------- bank mask table
  logic [MASK_W-1:0] mmem [MDEPTH];
  logic [MDEPTH-1:0] mvalid_r;
  logic [MASK_W-1:0] mask_q;
  logic              mvld_q;

  always_ff @(posedge clk) begin
    if (cmd.mask_wr && mask_ok_r) begin
      mmem[maddr_r] <= maskv_r;
    end
    mask_q <= mmem[maddr_r];
    mvld_q <= mvalid_r[maddr_r] && mask_ok_r;
  end

  // Entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mvalid_r <= '0;
    end else if (cmd.mask_wr && mask_ok_r) begin
      mvalid_r[maddr_r] <= 1'b1;
    end
  end

  // ------------------------------------------------------ gradual reset timer
  logic [IVL_W-1:0]    cyc_r;
  logic [ROW_BITS-1:0] cursor_r;
  logic [IVL_W-1:0]    ivl_eff;
  logic                due;
  logic [ROW_BITS-1:0] cur;

  assign ivl_eff = (interval_r == '0) ? IVL_W'(1) : interval_r;
  assign due     = cyc_r >= ivl_eff;
  assign cur     = cursor_r & emask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cyc_r    <= '0;
      cursor_r <= '0;
    end else if (cmd.tick) begin
      if (due) begin
        cyc_r    <= cyc_r - ivl_eff + IVL_W'(1);
        cursor_r <= (cur + ROW_BITS'(1)) & emask;
      end else begin
        cyc_r <= cyc_r + IVL_W'(1);
      end
    end
  end

  // ------------------------------------------------------ power-up clear pass
  logic [ROW_BITS-1:0] sweep_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_addr_r <= '0;
    end else if (cmd.sweep) begin
      sweep_addr_r <= sweep_addr_r + ROW_BITS'(1);
    end
  end

  // ------------------------------------------------------------ table index
  logic [MASK_W-1:0]   bm;
  logic [ROW_W-1:0]    base;
  logic [ROW_BITS-1:0] idx_nxt;
  logic [ROW_BITS-1:0] idx_r;

  assign bm      = mvld_q ? mask_q : '0;
  assign base    = grouping_r ? (row_r ^ bm) : row_r;
  assign idx_nxt = ROW_BITS'(base) & emask;

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      idx_r <= idx_nxt;
    end
  end

  // ---------------------------------------------- counter memory, one word per
  // entry holding the counters of all ranks side by side
  logic [WORD_W-1:0]   cmem [ENTRIES];
  logic [WORD_W-1:0]   cword_q;
  logic                c_we;
  logic [ROW_BITS-1:0] c_waddr;
  logic [WORD_W-1:0]   c_wdata;
  logic [WORD_W-1:0]   word_new;

  always_ff @(posedge clk) begin
    if (c_we) begin
      cmem[c_waddr] <= c_wdata;
    end
    if (cmd.lookup) begin
      cword_q <= cmem[idx_nxt];
    end
  end

  // Counter increment, threshold compare and word merge
  logic [COUNTER_BITS-1:0] cnt_old;
  logic [COUNTER_BITS-1:0] cnt_inc;
  logic [COUNTER_BITS-1:0] cnt_new;
  logic                    hit;

  always_comb begin
    cnt_old = '0;
    for (int r = 0; r < RANK_COUNT; r++) begin
      if (int'(rank_r) == r) begin
        cnt_old = cword_q[r*COUNTER_BITS +: COUNTER_BITS];
      end
    end
    cnt_inc = (&cnt_old) ? cnt_old : cnt_old + COUNTER_BITS'(1);
    hit     = CMP_W'(cnt_inc) >= CMP_W'(threshold_r);
    cnt_new = hit ? COUNTER_BITS'(1) : cnt_inc;
    word_new = cword_q;
    for (int r = 0; r < RANK_COUNT; r++) begin
      if (int'(rank_r) == r) begin
        word_new[r*COUNTER_BITS +: COUNTER_BITS] = cnt_new;
      end
    end
  end

  // Single write port: clear pass, cursor clear, or activate write-back
  always_comb begin
    c_we    = 1'b0;
    c_waddr = idx_r;
    c_wdata = word_new;
    if (cmd.sweep) begin
      c_we    = 1'b1;
      c_waddr = sweep_addr_r;
      c_wdata = '0;
    end else if (cmd.tick && due) begin
      c_we    = 1'b1;
      c_waddr = cur;
      c_wdata = '0;
    end else if (cmd.update) begin
      c_we = 1'b1;
    end
  end

  // ---------------------------------------------------------------- result
  logic               res_mit_r;
  logic [DRFM_W-1:0]  res_drfm_r;
  logic [RANK_W-1:0]  res_rank_r;
  logic [INDEX_W-1:0] res_idx_r;
  logic [COUNT_W-1:0] res_cnt_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_mit_r  <= 1'b0;
      res_drfm_r <= '0;
      res_rank_r <= '0;
      res_idx_r  <= '0;
      res_cnt_r  <= '0;
    end else if (cmd.update) begin
      res_mit_r  <= hit;
      res_drfm_r <= hit ? (DRFM_W'(1) << sharing_r) : '0;
      res_rank_r <= hit ? rank_r : '0;
      res_idx_r  <= INDEX_W'(idx_r);
      res_cnt_r  <= COUNT_W'(cnt_new);
    end
  end

  // Output register
  logic               out_valid_r;
  logic               out_mit_r;
  logic [DRFM_W-1:0]  out_drfm_r;
  logic [RANK_W-1:0]  out_rank_r;
  logic [INDEX_W-1:0] out_idx_r;
  logic [COUNT_W-1:0] out_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_mit_r  <= res_mit_r;
      out_drfm_r <= res_drfm_r;
      out_rank_r <= res_rank_r;
      out_idx_r  <= res_idx_r;
      out_cnt_r  <= res_cnt_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_mit_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_cnt_r, out_idx_r, out_rank_r, out_drfm_r};

  // ---------------------------------------------------------------- status
  assign sts.sweep_done = &sweep_addr_r;
  assign sts.in_is_mask = (in_op == OP_MASK);
  assign sts.is_act     = act_r;
  assign sts.out_free   = !out_valid_r || out_tready;

  // ------------------------------------------------------------ assertions
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (!out_valid_r || out_tready))
    else $error("result overwrote an unread output");

  a_wport_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.sweep, cmd.tick, cmd.update}))
    else $error("counter memory write port contention");

  a_mit_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_mit_r |-> (out_cnt_r == COUNT_W'(1)))
    else $error("mitigation without counter reset to one");

  a_drfm_mit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_drfm_r != '0) == out_mit_r))
    else $error("refresh count does not match mitigation flag");

endmodule

`default_nettype wire

// ===== src/shared_activation_counter_mitigation.sv =====
// Top level of the shared activation counter mitigation block.
// Joins the controller FSM and datapath. Depends on sacm_pkg, sacm_ctrl,
// sacm_dpath.
//
// Usage:
//   in_*  : one transaction per controller cycle item; in_tuser is the
//           opcode (idle, activate, mask write), in_tdata the item fields.
//   out_* : exactly one result transaction per input transaction, in order;
//           out_tuser flags a mitigation, out_tdata carries the refresh
//           count, rank, table index and counter value (zeros if no activate).
//   cfg_* : register writes, always ready; write only while the block is idle.
// Timing: an idle item passes through the timer tick and result states, a
//   mask write through the mask table write and result; an activate through
//   timer tick, index and counter read, write-back and result. The next item
//   is taken only once the result has moved into the output register.
// Reset: synchronous, active low. After reset a clear pass zeroes all
//   2^ROW_BITS counter memory words (65536 by default), one word per cycle,
//   with in_tready low; config writes are taken during it.
// Back-pressure: the result sits in an output register; the next item is
//   still accepted and worked on, and only its hand-off waits for out_tready.
`default_nettype none

module shared_activation_counter_mitigation #(
  parameter int RANK_COUNT     = sacm_pkg::RANK_COUNT_DEF,
  parameter int BANKS_PER_RANK = sacm_pkg::BANKS_PER_RANK_DEF,
  parameter int ROW_BITS       = sacm_pkg::ROW_BITS_DEF,
  parameter int COUNTER_BITS   = sacm_pkg::COUNTER_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  // input stream
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // [0] rank, [5:1] bank, [21:6] row, [37:22] mask_value, [39:38] zero
  input  wire  [sacm_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [1:0] opcode
  input  wire  [sacm_pkg::OPCODE_W-1:0]     in_tuser,
  // result stream
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // [3:0] drfm_count, [4] drfm_rank, [20:5] table_index,
  // [36:21] count_after, [39:37] zero
  output logic [sacm_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [0] mitigate
  output logic                              out_tuser,
  // config write channel
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [sacm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [sacm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sacm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  sacm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sacm_dpath #(
    .RANK_COUNT     (RANK_COUNT),
    .BANKS_PER_RANK (BANKS_PER_RANK),
    .ROW_BITS       (ROW_BITS),
    .COUNTER_BITS   (COUNTER_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

`default_nettype wire
